FILE: design/tsa_pkg.sv
package tsa_pkg;

    localparam int PACKET_LEN_DEFAULT = 188;
    localparam int SYNC_COUNT_DEFAULT = 4;

    localparam int BYTE_W     = 8;
    localparam int LOCK_W     = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [BYTE_W-1:0] SYNC_VALUE_RESET = 8'h47;
    localparam logic [LOCK_W-1:0] LOCK_COUNT_RESET = 3'd4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_SYNC_VALUE = 2'd0;
    localparam t_cfg_index CFG_LOCK_COUNT = 2'd1;

    // one bank of the lookahead line: enable and write data; the shared pointer is a separate port
    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] wdata;
    } t_bank_ctl;

endpackage

FILE: design/tsa_delay_bank.sv
module tsa_delay_bank #(
    parameter int DEPTH = tsa_pkg::PACKET_LEN_DEFAULT - 1
) (
    input  logic                       i_clk,
    input  tsa_pkg::t_bank_ctl         i_ctl,
    input  logic [$clog2(DEPTH)-1:0]   i_addr,
    output logic [tsa_pkg::BYTE_W-1:0] o_rdata
);

    logic [tsa_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [tsa_pkg::BYTE_W-1:0] r_rdata;

    // read-before-write: the old entry leaves as the new one goes in
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_ctl.wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ts_packet_sync_aligner.sv
// channel   direction  handshake                 payload
// in        to block   i_in_valid / o_in_stall   i_data_byte[7:0]
// out       from block o_out_valid / i_out_stall o_out_byte[7:0], o_packet_start
// cfg       to block   i_cfg_we                  i_cfg_index, i_cfg_data[7:0]
//
// One byte a cycle unless the output stalls; results leave via decision and output registers.
// The lookahead line is SYNC_COUNT banks of PACKET_LEN-1 bytes, each one read and one
// write per cycle; first result follows the SYNC_COUNT*PACKET_LEN-th input byte.
// Reset clears control state only; line contents are undefined until written.
// A stalled output holds the decision stage with a result; input stalls only when full.
module ts_packet_sync_aligner #(
    parameter int PACKET_LEN = tsa_pkg::PACKET_LEN_DEFAULT,
    parameter int SYNC_COUNT = tsa_pkg::SYNC_COUNT_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tsa_pkg::BYTE_W-1:0]    i_data_byte,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tsa_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_packet_start,

    input  logic                          i_cfg_we,
    input  tsa_pkg::t_cfg_index           i_cfg_index,
    input  logic [tsa_pkg::BYTE_W-1:0]    i_cfg_data
);

    localparam int DEPTH   = PACKET_LEN - 1;
    localparam int AW      = $clog2(DEPTH);
    localparam int LINE    = PACKET_LEN * SYNC_COUNT;
    localparam int FW      = $clog2(LINE);
    localparam int LW      = $clog2(PACKET_LEN);
    localparam int NW      = 4;

    localparam logic [AW-1:0] PTR_LAST  = AW'(DEPTH - 1);
    localparam logic [FW-1:0] FILL_LAST = FW'(LINE - 1);
    localparam logic [LW-1:0] LEFT_INIT = LW'(PACKET_LEN - 1);
    localparam logic [NW-1:0] SYNC_CNT  = NW'(SYNC_COUNT);

    logic [tsa_pkg::BYTE_W-1:0] r_sync;
    logic [tsa_pkg::LOCK_W-1:0] r_lock;

    logic [AW-1:0]  r_ptr;
    logic [FW-1:0]  r_fill;
    logic           r_s1_v;
    logic           r_s1_full;
    logic [LW-1:0]  r_left;
    logic           r_run;

    logic                       r_out_v;
    logic [tsa_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_out_start;

    logic [tsa_pkg::BYTE_W-1:0] rd [SYNC_COUNT];

    logic                       accept;
    logic                       out_free;
    logic                       s1_adv;
    logic                       has_result;
    logic                       emit_cont;
    logic                       take;
    logic                       look_ok;
    logic [NW-1:0]              need;
    logic [tsa_pkg::BYTE_W-1:0] hb;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync <= tsa_pkg::SYNC_VALUE_RESET;
            r_lock <= tsa_pkg::LOCK_COUNT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == tsa_pkg::CFG_SYNC_VALUE) begin
                r_sync <= i_cfg_data;
            end
            if (i_cfg_index == tsa_pkg::CFG_LOCK_COUNT) begin
                r_lock <= i_cfg_data[tsa_pkg::LOCK_W-1:0];
            end
        end
    end

    // ---------------- lookahead line ----------------
    // bank j output lags the newest byte by (j+1)*PACKET_LEN-1 transfers
    genvar j;
    generate
        for (j = 0; j < SYNC_COUNT; j++) begin : g_bank
            tsa_pkg::t_bank_ctl ctl;
            if (j == 0) begin : g_first
                assign ctl.wdata = i_data_byte;
            end else begin : g_chain
                assign ctl.wdata = rd[j-1];
            end
            assign ctl.en = accept;

            tsa_delay_bank #(
                .DEPTH (DEPTH)
            ) u_bank (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_addr  (r_ptr),
                .o_rdata (rd[j])
            );
        end
    endgenerate

    // ---------------- decision stage ----------------
    assign hb        = rd[SYNC_COUNT-1];
    assign emit_cont = (r_left != '0);

    always_comb begin
        if (r_lock == '0) begin
            need = NW'(1);
        end else if ({1'b0, r_lock} > SYNC_CNT) begin
            need = SYNC_CNT;
        end else begin
            need = {1'b0, r_lock};
        end
    end

    // tap k sits k packets behind the head
    always_comb begin
        look_ok = 1'b1;
        for (int k = 1; k < SYNC_COUNT; k++) begin
            if (NW'(k) < need && rd[SYNC_COUNT-1-k] != r_sync) begin
                look_ok = 1'b0;
            end
        end
    end

    assign take       = (hb == r_sync) && (r_run || look_ok);
    assign has_result = r_s1_full && (emit_cont || take);
    assign out_free   = !r_out_v || !i_out_stall;
    assign s1_adv     = r_s1_v && (!has_result || out_free);
    assign o_in_stall = r_s1_v && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_fill    <= '0;
            r_s1_v    <= 1'b0;
            r_s1_full <= 1'b0;
        end else if (accept) begin
            r_ptr     <= (r_ptr == PTR_LAST) ? '0 : r_ptr + AW'(1);
            r_s1_v    <= 1'b1;
            r_s1_full <= (r_fill == FILL_LAST);
            if (r_fill != FILL_LAST) begin
                r_fill <= r_fill + FW'(1);
            end
        end else if (s1_adv) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_run  <= 1'b0;
        end else if (s1_adv && r_s1_full) begin
            priority if (emit_cont) begin
                r_left <= r_left - LW'(1);
            end else if (take) begin
                r_run  <= 1'b1;
                r_left <= LEFT_INIT;
            end else begin
                r_run  <= 1'b0;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_adv && has_result) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && has_result) begin
            r_out_byte  <= hb;
            r_out_start <= !emit_cont;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_out_byte     = r_out_byte;
    assign o_packet_start = r_out_start;

    // ---------------- assertions ----------------
    a_left_in_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |-> r_run)
        else $error("packet in progress without an active run");

    a_quiet_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != FILL_LAST) |-> (!r_run && r_left == '0 && !r_out_v))
        else $error("activity before the lookahead line is full");

    a_run_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_run) |-> (r_left == LEFT_INIT && r_out_v && r_out_start))
        else $error("run started without a packet start");

endmodule

FILE: tb/ts_packet_sync_aligner_tb.sv
`timescale 1ns / 1ps

module ts_packet_sync_aligner_tb;

    import tsa_pkg::*;

    localparam int PKT         = PACKET_LEN_DEFAULT;
    localparam int DEPTH       = SYNC_COUNT_DEFAULT;
    localparam int LINE_LEN    = PKT * DEPTH;
    localparam int SETTLE_CYC  = 8;
    localparam int TAIL_CYC    = 20;
    localparam int HOLD_CYC    = 300;
    localparam int STUCK_LIMIT = 4000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
    } aligned_byte_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [BYTE_W-1:0]  i_data_byte;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [BYTE_W-1:0]  o_out_byte;
    logic               o_packet_start;
    logic               i_cfg_we;
    t_cfg_index         i_cfg_index;
    logic [BYTE_W-1:0]  i_cfg_data;

    // predictor state
    logic [BYTE_W-1:0]  line_mem [LINE_LEN];
    int unsigned        wr_ptr;
    int unsigned        fill_level;
    int unsigned        left_in_pkt;
    bit                 in_run;
    logic [BYTE_W-1:0]  cur_sync;
    logic [LOCK_W-1:0]  cur_lock;

    aligned_byte_t      expected_bytes [$];
    aligned_byte_t      oldest_expected;
    int                 fail_count;
    int                 in_idle_pct;
    int                 out_stall_pct;
    int                 hold_off_left;
    int                 stuck_cycles;

    ts_packet_sync_aligner u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_packet_start (o_packet_start),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // push one byte into the line; decide on the head once the line is full
    function automatic void predict_aligned_output(input logic [BYTE_W-1:0] b,
                                                   output bit emit,
                                                   output aligned_byte_t res);
        int unsigned head;
        int unsigned need;
        int unsigned k;
        bit          ok;
        emit = 1'b0;
        res  = '0;
        line_mem[wr_ptr] = b;
        wr_ptr = (wr_ptr + 1) % LINE_LEN;
        fill_level++;
        if (fill_level < LINE_LEN)
            return;
        fill_level--;
        head = wr_ptr;
        if (left_in_pkt != 0) begin
            left_in_pkt--;
            emit      = 1'b1;
            res.data  = line_mem[head];
            res.start = 1'b0;
            return;
        end
        ok = (line_mem[head] == cur_sync);
        if (ok && !in_run) begin
            need = (cur_lock == 0) ? 1 : cur_lock;
            if (need > DEPTH)
                need = DEPTH;
            for (k = 1; k < need; k++) begin
                if (line_mem[(head + k * PKT) % LINE_LEN] != cur_sync)
                    ok = 1'b0;
            end
        end
        if (!ok) begin
            in_run = 1'b0;
            return;
        end
        in_run      = 1'b1;
        left_in_pkt = PKT - 1;
        emit        = 1'b1;
        res.data    = line_mem[head];
        res.start   = 1'b1;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        bit            emit;
        aligned_byte_t res;
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predict_aligned_output(b, emit, res);
        if (emit)
            expected_bytes.push_back(res);
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_byte($urandom_range(255));
    endtask

    task automatic send_packet(input logic [BYTE_W-1:0] first);
        send_byte(first);
        send_noise(PKT - 1);
    endtask

    // mostly aligned packets; some bad sync bytes, cut packets and junk between
    task automatic send_mixed_stream(input int n_bytes);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_packet(cur_sync);
                sent += PKT;
            end else if (pick < 87) begin
                send_packet(cur_sync ^ (8'd1 << $urandom_range(7)));
                sent += PKT;
            end else if (pick < 93) begin
                len = $urandom_range(PKT - 2, 1);
                send_byte(cur_sync);
                send_noise(len);
                sent += len + 1;
            end else begin
                len = $urandom_range(30, 1);
                send_noise(len);
                sent += len;
            end
        end
    endtask

    // let every expected transfer arrive, then let the decision stage empty
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [BYTE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SYNC_VALUE: cur_sync = value;
            CFG_LOCK_COUNT: cur_lock = value[LOCK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_rates(input int in_pct, input int out_pct);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
    endtask

    // first results only after the line has filled, reset settings
    task automatic test_line_fill();
        set_rates(0, 0);
        send_byte(8'h00);
        send_byte(8'hFF);
        repeat (5) send_packet(cur_sync);
        wait_drained();
    endtask

    // a bad sync byte breaks the run; the lock check has to pass again
    task automatic test_run_break();
        send_packet(cur_sync ^ 8'h80);
        repeat (4) send_packet(cur_sync);
        send_noise(7);
        repeat (4) send_packet(cur_sync);
        wait_drained();
    endtask

    task automatic test_lock_limits();
        // zero acts as one
        write_reg(CFG_SYNC_VALUE, 8'h00);
        write_reg(CFG_LOCK_COUNT, 8'h00);
        send_mixed_stream(400);
        wait_drained();
        // above the line depth saturates; upper data bits are ignored
        write_reg(CFG_SYNC_VALUE, 8'hFF);
        write_reg(CFG_LOCK_COUNT, 8'hFF);
        send_mixed_stream(400);
        wait_drained();
        write_reg(CFG_LOCK_COUNT, 8'h05);
        send_mixed_stream(400);
        wait_drained();
    endtask

    task automatic run_idle_phase(input int in_pct, input int out_pct,
                                  input logic [LOCK_W-1:0] lock);
        write_reg(CFG_SYNC_VALUE, $urandom_range(255));
        write_reg(CFG_LOCK_COUNT, {$urandom_range(31), lock});
        set_rates(in_pct, out_pct);
        send_mixed_stream(200);
        wait_drained();
    endtask

    task automatic test_idle_phases();
        run_idle_phase(0, 0, 3'd1);
        run_idle_phase(79, 0, 3'd2);
        run_idle_phase(0, 79, 3'd3);
        run_idle_phase(28, 28, 3'd4);
    endtask

    // output held off while input keeps coming, then a full pause and random idles and stalls
    task automatic test_backpressure();
        set_rates(0, 0);
        @(negedge i_clk);
        hold_off_left = HOLD_CYC;
        send_mixed_stream(120);
        wait_drained();
        set_rates(28, 28);
        send_mixed_stream(200);
    endtask

    // receiver side
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                i_out_stall <= 1'b1;
                hold_off_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                if (fail_count < 10)
                    $display("%0t: unexpected transfer byte %02h start %0b",
                             $time, o_out_byte, o_packet_start);
                fail_count++;
            end else begin
                oldest_expected = expected_bytes.pop_front();
                if (o_out_byte !== oldest_expected.data ||
                    o_packet_start !== oldest_expected.start) begin
                    if (fail_count < 10)
                        $display("%0t: expected byte %02h start %0b, got byte %02h start %0b",
                                 $time, oldest_expected.data, oldest_expected.start,
                                 o_out_byte, o_packet_start);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
            $display("ts_packet_sync_aligner_tb: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_data_byte   = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_SYNC_VALUE;
        i_cfg_data    = '0;
        wr_ptr        = 0;
        fill_level    = 0;
        left_in_pkt   = 0;
        in_run        = 1'b0;
        cur_sync      = SYNC_VALUE_RESET;
        cur_lock      = LOCK_COUNT_RESET;
        fail_count    = 0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_off_left = 0;
        stuck_cycles  = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_line_fill();
        test_run_break();
        test_lock_limits();
        test_idle_phases();
        test_backpressure();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (fail_count == 0)
            $display("ts_packet_sync_aligner_tb: PASS");
        else
            $display("ts_packet_sync_aligner_tb: FAIL");
        $finish;
    end

endmodule
